@@ hdl/ctw_pkg.sv @@
// Shared constants, codes and helpers of the text console character writer.
package ctw_pkg;

	// Default grid geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// Fixed field widths of the stream words
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int RROW_W  = 5;
	localparam int RCOL_W  = 7;
	localparam int CELL_W  = 16;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	// Function codes
	localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

	// Character codes and blank attribute after reset
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
	localparam logic [ATTR_W-1:0] FILL_RESET   = 8'd15;

	// Build a cell: attribute in the high byte, character in the low byte
	function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch,
			logic [ATTR_W-1:0] attr);
		return {attr, ch};
	endfunction

endpackage

@@ hdl/text_console_char_writer_unit.sv @@
// Text console character writer: top level with stream ports and configuration.
//
// Keeps a ROWS x COLS grid of 16-bit cells (attribute high byte, character low
// byte) in one single-port RAM, plus a cursor, and answers every input word with
// one result word. All grid traffic goes through the one RAM port, addressed by a
// row-rotating address unit, so scrolling only blanks one row and moves a top-row
// offset. A put that scrolls also blanks the new bottom row, and a clear blanks
// every cell of the grid. s_tready is low while a word is being worked on, and
// a result word that is not taken holds the block until the previous one
// leaves. After reset the block runs a clearing pass over all ROWS*COLS cells
// (2000 at the default size) before it accepts the first word; configuration
// writes are taken at any time.
module text_console_char_writer_unit
	import ctw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [7:0] char_code, [15:8] attribute, [20:16] read_row, [27:21] read_col
	input  logic [S_DATA_W-1:0] s_tdata,
	// [1:0] func
	input  logic [FUNC_W-1:0]   s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [15:0] cell_value, [22:16] cursor_col, [27:23] cursor_row
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ATTR_W-1:0]   cfg_data
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = $clog2(ROWS*COLS);

	logic [ATTR_W-1:0] fill_q;
	logic              mem_we;
	logic [ROW_W-1:0]  mem_row;
	logic [COL_W-1:0]  mem_col;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;
	logic [ROW_W-1:0]  top_row;
	logic [ADDR_W-1:0] mem_addr;
	logic [CELL_W-1:0] cell_value;
	logic [RCOL_W-1:0] cursor_col;
	logic [RROW_W-1:0] cursor_row;

	// Take the fill attribute at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (cfg_valid) begin
			fill_q <= cfg_data;
		end
	end

	// Pack the result word
	assign m_tdata = {(M_DATA_W-CELL_W-RCOL_W-RROW_W)'(0), cursor_row, cursor_col,
		cell_value};

	ctw_seq #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.func       (s_tuser),
		.char_code  (s_tdata[7:0]),
		.attribute  (s_tdata[15:8]),
		.read_row   (s_tdata[20:16]),
		.read_col   (s_tdata[27:21]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cell_value (cell_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.fill_attr  (fill_q),
		.mem_we     (mem_we),
		.mem_row    (mem_row),
		.mem_col    (mem_col),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.top_row    (top_row)
	);

	ctw_addr #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_addr (
		.row     (mem_row),
		.col     (mem_col),
		.top_row (top_row),
		.addr    (mem_addr)
	);

	ctw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(ROWS*COLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

@@ hdl/ctw_ram.sv @@
// Generic single-port RAM with registered read.
module ctw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ hdl/ctw_addr.sv @@
// Address unit: maps a logical row and column onto the circular grid memory.
module ctw_addr
	import ctw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic [$clog2(ROWS)-1:0]        row,
	input  logic [$clog2(COLS)-1:0]        col,
	input  logic [$clog2(ROWS)-1:0]        top_row,
	output logic [$clog2(ROWS*COLS)-1:0]   addr
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(ROWS*COLS);

	logic [ROW_W:0]   row_sum;
	logic [ROW_W-1:0] phys_row;

	// Rotate the row by the top offset, wrapping at the last row
	always_comb begin
		row_sum = {1'b0, row} + {1'b0, top_row};
		if (row_sum >= (ROW_W+1)'(ROWS)) begin
			phys_row = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
		end else begin
			phys_row = row_sum[ROW_W-1:0];
		end
		addr = ADDR_W'(phys_row) * ADDR_W'(COLS) + ADDR_W'(col);
	end

endmodule

@@ hdl/ctw_seq.sv @@
// Sequencer: cursor, scroll offset, sweeps and the result word register.
module ctw_seq
	import ctw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [FUNC_W-1:0]         func,
	input  logic [CHAR_W-1:0]         char_code,
	input  logic [ATTR_W-1:0]         attribute,
	input  logic [RROW_W-1:0]         read_row,
	input  logic [RCOL_W-1:0]         read_col,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [CELL_W-1:0]         cell_value,
	output logic [RCOL_W-1:0]         cursor_col,
	output logic [RROW_W-1:0]         cursor_row,
	input  logic [ATTR_W-1:0]         fill_attr,
	output logic                      mem_we,
	output logic [$clog2(ROWS)-1:0]   mem_row,
	output logic [$clog2(COLS)-1:0]   mem_col,
	output logic [CELL_W-1:0]         mem_wdata,
	input  logic [CELL_W-1:0]         mem_rdata,
	output logic [$clog2(ROWS)-1:0]   top_row
);

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] top_q;
	logic [ROW_W-1:0] sw_row_q;
	logic [COL_W-1:0] sw_col_q;
	logic [ATTR_W-1:0] blank_attr_q;
	logic             reply_q;
	logic [CELL_W-1:0] cell_q;
	logic             out_valid_q;
	logic [CELL_W-1:0] out_cell_q;
	logic [RCOL_W-1:0] out_col_q;
	logic [RROW_W-1:0] out_row_q;

	logic             accept;
	logic             out_free;
	logic             read_ok;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;
	logic             adv_row;
	logic             scroll;
	logic [ROW_W-1:0] top_inc;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign m_tvalid   = out_valid_q;
	assign cell_value = out_cell_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign top_row    = top_q;
	assign read_ok    = ({1'b0, read_row} < (RROW_W+1)'(ROWS)) &&
		({1'b0, read_col} < (RCOL_W+1)'(COLS));
	assign top_inc    = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;

	// Work out the cursor after a put
	always_comb begin
		adv_row = 1'b0;
		nxt_col = cur_col_q;
		if (char_code == CH_NEWLINE) begin
			adv_row = 1'b1;
			nxt_col = '0;
		end else if (char_code == CH_BACKSPACE) begin
			if (cur_col_q != '0) begin
				nxt_col = cur_col_q - 1'b1;
			end
		end else if (cur_col_q == LAST_COL) begin
			adv_row = 1'b1;
			nxt_col = '0;
		end else begin
			nxt_col = cur_col_q + 1'b1;
		end
		scroll  = adv_row && (cur_row_q == LAST_ROW);
		nxt_row = (adv_row && !scroll) ? cur_row_q + 1'b1 : cur_row_q;
	end

	// Drive the memory port from the sweep or the accepted word
	always_comb begin
		mem_we    = 1'b0;
		mem_row   = cur_row_q;
		mem_col   = cur_col_q;
		mem_wdata = make_cell(CH_BLANK, blank_attr_q);
		if (state_q == ST_SWEEP) begin
			mem_we  = 1'b1;
			mem_row = sw_row_q;
			mem_col = sw_col_q;
		end else if (accept) begin
			case (func)
				FN_PUT: begin
					if (char_code == CH_BACKSPACE) begin
						mem_we    = (cur_col_q != '0);
						mem_col   = cur_col_q - 1'b1;
						mem_wdata = make_cell(CH_BLANK, attribute);
					end else if (char_code != CH_NEWLINE) begin
						mem_we    = 1'b1;
						mem_wdata = make_cell(char_code, attribute);
					end
				end
				FN_READ: begin
					mem_row = ROW_W'(read_row);
					mem_col = COL_W'(read_col);
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// Hold state, cursor and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			top_q        <= '0;
			sw_row_q     <= '0;
			sw_col_q     <= '0;
			blank_attr_q <= FILL_RESET;
			reply_q      <= 1'b0;
			cell_q       <= '0;
			out_valid_q  <= 1'b0;
			out_cell_q   <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
		end else begin
			// Raise the result word when it is built, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					if (sw_col_q == LAST_COL) begin
						sw_col_q <= '0;
						if (sw_row_q == LAST_ROW) begin
							cell_q  <= '0;
							state_q <= reply_q ? ST_DONE : ST_IDLE;
						end else begin
							sw_row_q <= sw_row_q + 1'b1;
						end
					end else begin
						sw_col_q <= sw_col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cell_q <= '0;
						case (func)
							FN_PUT: begin
								cur_row_q <= nxt_row;
								cur_col_q <= nxt_col;
								if (scroll) begin
									top_q        <= top_inc;
									sw_row_q     <= LAST_ROW;
									sw_col_q     <= '0;
									blank_attr_q <= fill_attr;
									reply_q      <= 1'b1;
									state_q      <= ST_SWEEP;
								end else begin
									state_q <= ST_DONE;
								end
							end
							FN_CLEAR: begin
								cur_row_q    <= '0;
								cur_col_q    <= '0;
								top_q        <= '0;
								sw_row_q     <= '0;
								sw_col_q     <= '0;
								blank_attr_q <= fill_attr;
								reply_q      <= 1'b1;
								state_q      <= ST_SWEEP;
							end
							FN_READ: begin
								state_q <= read_ok ? ST_READ : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					cell_q  <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_cell_q  <= cell_q;
						out_col_q   <= RCOL_W'(cur_col_q);
						out_row_q   <= RROW_W'(cur_row_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps

module tb;
	import ctw_pkg::*;

	localparam int NCOLS = COLS_DEF;
	localparam int NROWS = ROWS_DEF;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int WORDS_PER_PHASE = 200;

	// Expected content of one result word
	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic [RCOL_W-1:0] col;
		logic [RROW_W-1:0] row;
	} cursor_report_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// [7:0] char_code, [15:8] attribute, [20:16] read_row, [27:21] read_col
	logic [S_DATA_W-1:0] s_tdata;
	// [1:0] func
	logic [FUNC_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// [15:0] cell_value, [22:16] cursor_col, [27:23] cursor_row
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [ATTR_W-1:0]   cfg_data;

	// Shadow copy of the console: grid, cursor and blank attribute
	logic [CELL_W-1:0] shadow_grid [NROWS][NCOLS];
	logic [RCOL_W-1:0] shadow_col;
	logic [RROW_W-1:0] shadow_row;
	logic [ATTR_W-1:0] shadow_fill;

	cursor_report_t pending_reports [$];
	int  error_cnt;
	int  words_sent;
	bit  tx_idle;
	bit  rx_idle;

	text_console_char_writer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Blank every cell of the shadow grid with the current fill and home the cursor
	function automatic void blank_grid();
		for (int r = 0; r < NROWS; r++)
			for (int c = 0; c < NCOLS; c++)
				shadow_grid[r][c] = {shadow_fill, CH_BLANK};
		shadow_col = '0;
		shadow_row = '0;
	endfunction

	// Apply one accepted word to the shadow console and return the expected report
	function automatic cursor_report_t console_step(logic [FUNC_W-1:0] fn,
			logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr,
			logic [RROW_W-1:0] rrow, logic [RCOL_W-1:0] rcol);
		cursor_report_t rep;
		rep.cell_val = '0;
		case (fn)
			FN_PUT: begin
				if (ch == CH_NEWLINE) begin
					shadow_col = '0;
					shadow_row = shadow_row + 1'b1;
				end else if (ch == CH_BACKSPACE) begin
					if (shadow_col != 0) begin
						shadow_col = shadow_col - 1'b1;
						shadow_grid[shadow_row][shadow_col] = {attr, CH_BLANK};
					end
				end else begin
					shadow_grid[shadow_row][shadow_col] = {attr, ch};
					shadow_col = shadow_col + 1'b1;
				end
				// Wrap at the right edge
				if (shadow_col >= NCOLS) begin
					shadow_col = '0;
					shadow_row = shadow_row + 1'b1;
				end
				// Scroll up one row and blank the bottom row
				if (shadow_row >= NROWS) begin
					for (int r = 0; r < NROWS - 1; r++)
						shadow_grid[r] = shadow_grid[r + 1];
					for (int c = 0; c < NCOLS; c++)
						shadow_grid[NROWS - 1][c] = {shadow_fill, CH_BLANK};
					shadow_row = RROW_W'(NROWS - 1);
				end
			end
			FN_CLEAR: blank_grid();
			FN_READ: begin
				if (rrow < NROWS && rcol < NCOLS)
					rep.cell_val = shadow_grid[rrow][rcol];
			end
			default: ;
		endcase
		rep.col = shadow_col;
		rep.row = shadow_row;
		return rep;
	endfunction

	// Offer one word, after a random gap while tx_idle is set, and record its expected report on acceptance
	task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
			input logic [ATTR_W-1:0] attr, input logic [RROW_W-1:0] rrow,
			input logic [RCOL_W-1:0] rcol);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {4'b0, rcol, rrow, attr, ch};
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(console_step(fn, ch, attr, rrow, rcol));
		words_sent++;
	endtask

	// Drop valid and hold until every report is back and the block is free
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Write the blank attribute register while the block is idle
	task automatic write_fill(input logic [ATTR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_fill = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls while rx_idle is set, then check each word against the oldest expectation
	initial begin : result_check
		int gap;
		cursor_report_t exp_rep;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle ? $urandom_range(0, 3) : 0;
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h",
					$time, m_tdata);
				error_cnt++;
			end else begin
				exp_rep = pending_reports.pop_front();
				if (m_tdata[15:0] !== exp_rep.cell_val) begin
					$display("%0t: cell_value expected %h actual %h",
						$time, exp_rep.cell_val, m_tdata[15:0]);
					error_cnt++;
				end
				if (m_tdata[22:16] !== exp_rep.col) begin
					$display("%0t: cursor_col expected %0d actual %0d",
						$time, exp_rep.col, m_tdata[22:16]);
					error_cnt++;
				end
				if (m_tdata[27:23] !== exp_rep.row) begin
					$display("%0t: cursor_row expected %0d actual %0d",
						$time, exp_rep.row, m_tdata[27:23]);
					error_cnt++;
				end
			end
		end
	end

	// Blank grid after reset, corner reads, out-of-range reads, unused code
	task automatic test_reset_state();
		send_word(FN_READ, 8'h00, 8'hFF, 5'd0, 7'd0);
		send_word(FN_READ, 8'hFF, 8'h00, 5'(NROWS - 1), 7'(NCOLS - 1));
		send_word(FN_READ, 8'h00, 8'h00, 5'd31, 7'd127);
		send_word(FN_READ, 8'h00, 8'h00, 5'(NROWS), 7'd0);
		send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'(NCOLS));
		send_word(FN_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127);
	endtask

	// Character extremes, backspace in and at column 0, newline
	task automatic test_put_edit();
		send_word(FN_PUT, 8'h41, 8'h00, 5'd0, 7'd0);
		send_word(FN_PUT, 8'hFF, 8'hFF, 5'd0, 7'd0);
		send_word(FN_PUT, 8'h00, 8'h5A, 5'd0, 7'd0);
		send_word(FN_PUT, CH_BACKSPACE, 8'hA5, 5'd0, 7'd0);
		send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd2);
		send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd1);
		send_word(FN_PUT, CH_NEWLINE, 8'h33, 5'd0, 7'd0);
		send_word(FN_PUT, CH_BACKSPACE, 8'hC3, 5'd0, 7'd0);
		send_word(FN_READ, 8'h00, 8'h00, 5'd1, 7'd0);
	endtask

	// Fill change keeps old cells; later clears use the new fill
	task automatic test_fill_attribute();
		wait_idle();
		write_fill(8'h00);
		send_word(FN_READ, 8'h00, 8'h00, 5'd5, 7'd5);
		send_word(FN_READ, 8'h00, 8'h00, 5'd0, 7'd0);
		send_word(FN_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
		send_word(FN_READ, 8'h00, 8'h00, 5'd3, 7'd3);
		wait_idle();
		write_fill(8'hFF);
		send_word(FN_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127);
		send_word(FN_READ, 8'h00, 8'h00, 5'(NROWS - 1), 7'(NCOLS - 1));
	endtask

	// Text lines, newline runs that scroll, reads, odd codes and rare clears
	task automatic test_random_traffic();
		int phase;
		int target;
		int kind;
		int len;
		logic [ATTR_W-1:0] fill_v;
		logic [CHAR_W-1:0] ch;
		logic [RROW_W-1:0] rrow;
		logic [RCOL_W-1:0] rcol;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: fill_v = 8'hFF;
				1: fill_v = 8'h00;
				default: fill_v = 8'($urandom_range(1, 254));
			endcase
			wait_idle();
			write_fill(fill_v);
			// No idling on either side during one phase
			tx_idle = (phase != 2);
			rx_idle = (phase != 2);
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					// Mostly short lines, some long enough to wrap
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 170)
						: $urandom_range(0, 20);
					for (int k = 0; k < len; k++) begin
						ch = ($urandom_range(0, 11) == 0) ? CH_BACKSPACE : 8'($urandom);
						send_word(FN_PUT, ch, 8'($urandom), 5'($urandom), 7'($urandom));
					end
					if ($urandom_range(0, 3) != 0)
						send_word(FN_PUT, CH_NEWLINE, 8'($urandom), 5'($urandom),
							7'($urandom));
				end else if (kind < 72) begin
					len = $urandom_range(1, 30);
					for (int k = 0; k < len; k++)
						send_word(FN_PUT, CH_NEWLINE, 8'($urandom), 5'($urandom),
							7'($urandom));
				end else if (kind < 94) begin
					len = $urandom_range(1, 6);
					for (int k = 0; k < len; k++) begin
						case ($urandom_range(0, 3))
							0: begin
								rrow = 5'($urandom);
								rcol = 7'($urandom);
							end
							1: begin
								rrow = shadow_row;
								rcol = 7'($urandom_range(0, NCOLS - 1));
							end
							default: begin
								rrow = 5'($urandom_range(0, NROWS - 1));
								rcol = 7'($urandom_range(0, NCOLS - 1));
							end
						endcase
						send_word(FN_READ, 8'($urandom), 8'($urandom), rrow, rcol);
					end
				end else if (kind < 98) begin
					send_word(FN_UNUSED, 8'($urandom), 8'($urandom), 5'($urandom),
						7'($urandom));
				end else begin
					send_word(FN_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom),
						7'($urandom));
				end
			end
		end
	endtask

	// Reset, run the tests in turn, drain and report
	initial begin : run_tests
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		tx_idle    = 1'b1;
		rx_idle    = 1'b1;
		error_cnt  = 0;
		words_sent = 0;
		shadow_fill = FILL_RESET;
		blank_grid();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_put_edit();
		test_fill_attribute();
		test_random_traffic();

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin : watchdog
		#100_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
